// File: rtl/core/sbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg
// Types, token kinds, character codes and classification helpers shared by
// the source byte tokenizer and its submodules.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int MAX_RESULTS     = 4;
    localparam int RESULT_CNT_W    = $clog2(MAX_RESULTS + 1);
    // Must be a power of two; the queue pointers wrap naturally.
    localparam int QUEUE_DEPTH     = 8;
    localparam int LEN_MAX         = 16'hFFFF;

    // Token kinds.
    localparam logic [4:0] K_PLUS       = 5'd0;
    localparam logic [4:0] K_MINUS      = 5'd1;
    localparam logic [4:0] K_STAR       = 5'd2;
    localparam logic [4:0] K_SLASH      = 5'd3;
    localparam logic [4:0] K_PERCENT    = 5'd4;
    localparam logic [4:0] K_LPAREN     = 5'd5;
    localparam logic [4:0] K_RPAREN     = 5'd6;
    localparam logic [4:0] K_LBRACKET   = 5'd7;
    localparam logic [4:0] K_RBRACKET   = 5'd8;
    localparam logic [4:0] K_LBRACE     = 5'd9;
    localparam logic [4:0] K_RBRACE     = 5'd10;
    localparam logic [4:0] K_COMMA      = 5'd11;
    localparam logic [4:0] K_DOT        = 5'd12;
    localparam logic [4:0] K_SEMICOLON  = 5'd13;
    localparam logic [4:0] K_COLON      = 5'd14;
    localparam logic [4:0] K_ASSIGN     = 5'd15;
    localparam logic [4:0] K_EQUAL      = 5'd16;
    localparam logic [4:0] K_NOT        = 5'd17;
    localparam logic [4:0] K_NOT_EQUAL  = 5'd18;
    localparam logic [4:0] K_LESS       = 5'd19;
    localparam logic [4:0] K_LESS_EQ    = 5'd20;
    localparam logic [4:0] K_GREATER    = 5'd21;
    localparam logic [4:0] K_GREATER_EQ = 5'd22;
    localparam logic [4:0] K_AND        = 5'd23;
    localparam logic [4:0] K_OR         = 5'd24;
    localparam logic [4:0] K_UNKNOWN    = 5'd25;
    localparam logic [4:0] K_STRING     = 5'd26;
    localparam logic [4:0] K_INTEGER    = 5'd27;
    localparam logic [4:0] K_DECIMAL    = 5'd28;
    localparam logic [4:0] K_IDENT      = 5'd29;
    localparam logic [4:0] K_END        = 5'd30;

    // Character codes.
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_PIPE      = 8'h7C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_GREATER   = 8'h3E;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_STRING,
        MODE_STRING_ESC,
        MODE_NUMBER,
        MODE_NUMBER_DOT,
        MODE_DECIMAL,
        MODE_IDENT
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_byte;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_of_run;
    } t_token;

    // Tokens produced by one input transfer, packed from slot 0 upward.
    typedef struct packed {
        logic [RESULT_CNT_W-1:0]      count;
        t_token [MAX_RESULTS-1:0]     tok;
    } t_scan_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Kind of a one-byte operator; K_UNKNOWN when the byte is not one.
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h25:   k = K_PERCENT;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5B:   k = K_LBRACKET;
            8'h5D:   k = K_RBRACKET;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h2C:   k = K_COMMA;
            8'h2E:   k = K_DOT;
            8'h3B:   k = K_SEMICOLON;
            8'h3A:   k = K_COLON;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return (c == CH_EQUAL) || (c == CH_BANG) || (c == CH_LESS) ||
               (c == CH_GREATER) || (c == CH_AMP) || (c == CH_PIPE);
    endfunction

    // Kind of a held operator byte, alone or completed by its second byte.
    function automatic logic [4:0] op_kind(input logic [7:0] first, input logic paired);
        logic [4:0] k;
        case (first)
            CH_EQUAL:   k = paired ? K_EQUAL      : K_ASSIGN;
            CH_BANG:    k = paired ? K_NOT_EQUAL  : K_NOT;
            CH_LESS:    k = paired ? K_LESS_EQ    : K_LESS;
            CH_GREATER: k = paired ? K_GREATER_EQ : K_GREATER;
            CH_AMP:     k = paired ? K_AND        : K_UNKNOWN;
            CH_PIPE:    k = paired ? K_OR         : K_UNKNOWN;
            default:    k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] op_second(input logic [7:0] first);
        return ((first == CH_AMP) || (first == CH_PIPE)) ? first : CH_EQUAL;
    endfunction

endpackage

// File: rtl/core/source_byte_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming lexical scanner: at most one source byte per input transfer, tokens out
// as kind, start offset and length.
// ----------------------------------------------------------------------------
// The tokenizer takes one input transfer per clock cycle while input ready
// is high. Each transfer is scanned in the cycle it is accepted and its
// tokens (up to four, the last one flagged with last_of_run) are written
// into an eight-entry token queue behind any tokens already held; the queue
// hands out one token per cycle while the output side is ready. Input ready
// is high whenever the queue has room for a full burst of four tokens, so
// with the output side taking one token per cycle and the source averaging
// at most one token per byte, bytes flow at one per cycle; bursts longer
// than the queue's slack hold input ready low until it drains. Keywords
// come out as identifiers. After an end-of-source transfer the next byte
// starts a new source at offset zero.
// ----------------------------------------------------------------------------
module source_byte_tokenizer
    import sbt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_token   o_out_token
);

    logic         in_accept;
    t_scan_result scan_result;

    assign in_accept = i_in_valid && o_in_ready;

    sbt_scanner #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_result (scan_result)
    );

    sbt_token_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scan_result),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_token (o_out_token)
    );

endmodule

// File: rtl/core/sbt_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_scanner
// Scanner state and the per-byte token logic: takes one input transfer and
// produces the ordered list of tokens it completes, at most four.
// ----------------------------------------------------------------------------
module sbt_scanner
    import sbt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  t_in_item     i_item,
    output t_scan_result o_result
);

    localparam int OB       = OFFSET_BITS;
    localparam int EW       = OFFSET_BITS + 1;
    localparam int DW       = (EW > 17) ? EW : 17;
    localparam int NUM_CAND = 6;
    localparam int SW       = $clog2(MAX_RESULTS);

    // Candidate order matches the order tokens leave the scanner.
    localparam int C_MAIN  = 0;
    localparam int C_DOT   = 1;
    localparam int C_START = 2;
    localparam int C_FLUSH = 3;
    localparam int C_FDOT  = 4;
    localparam int C_END   = 5;

    t_scan_mode    r_mode, n_mode;
    logic [7:0]    r_pend, n_pend;
    logic [OB-1:0] r_begin, n_begin;
    logic [OB-1:0] r_pos, n_pos;

    logic [7:0]    c;
    logic          has, fin;
    logic [EW-1:0] p_end1;
    logic [OB-1:0] dot_pos, fdot_pos;

    logic [4:0]    s_kind;
    logic          s_emit;
    t_scan_mode    s_mode;
    logic [7:0]    s_pend;

    logic          do_start;
    logic          main_v, dot_v, fl_v, fdot_v;
    logic [4:0]    main_kind, fl_kind;
    logic [EW-1:0] main_end, fl_end;

    t_token                  cand [NUM_CAND];
    logic [NUM_CAND-1:0]     cand_v;
    logic [RESULT_CNT_W-1:0] cnt;
    t_scan_result            packed_res;

    function automatic t_token make_token(input logic [4:0] kind,
                                          input logic [OB-1:0] b,
                                          input logic [EW-1:0] e);
        logic [DW-1:0] diff;
        t_token        t;
        diff          = DW'(e) - DW'(b);
        t.token_kind  = kind;
        t.token_start = 16'(b);
        if (e < EW'(b)) begin
            t.token_length = 16'd0;
        end else if (diff > DW'(LEN_MAX)) begin
            t.token_length = 16'(LEN_MAX);
        end else begin
            t.token_length = 16'(diff);
        end
        t.last_of_run = 1'b0;
        return t;
    endfunction

    assign c        = i_item.char_byte;
    assign has      = i_item.has_byte;
    assign fin      = i_item.end_of_source;
    assign p_end1   = EW'(r_pos) + EW'(1);
    assign dot_pos  = (r_pos != '0) ? r_pos - OB'(1) : '0;

    // Classification of a byte that opens a new token.
    always_comb begin
        s_kind = single_kind(c);
        s_emit = 1'b0;
        s_mode = MODE_IDLE;
        s_pend = r_pend;
        if (s_kind != K_UNKNOWN) begin
            s_emit = 1'b1;
        end else if (is_op_start(c)) begin
            s_mode = MODE_OP;
            s_pend = c;
        end else if (c == CH_SLASH) begin
            s_mode = MODE_SLASH;
        end else if ((c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB) ||
                     (c == CH_NEWLINE)) begin
            s_mode = MODE_IDLE;
        end else if (c == CH_QUOTE) begin
            s_mode = MODE_STRING;
        end else if (is_digit(c)) begin
            s_mode = MODE_NUMBER;
        end else if (is_alpha(c) || (c == CH_UNDERSCORE)) begin
            s_mode = MODE_IDENT;
        end else begin
            s_emit = 1'b1;
        end
    end

    // Byte step: close the held token where this byte ends it, and open the next.
    always_comb begin
        n_mode    = r_mode;
        n_pend    = r_pend;
        n_begin   = r_begin;
        do_start  = 1'b0;
        main_v    = 1'b0;
        main_kind = K_UNKNOWN;
        main_end  = EW'(r_pos);
        dot_v     = 1'b0;
        if (has) begin
            case (r_mode)
                MODE_OP: begin
                    main_v = 1'b1;
                    if (c == op_second(r_pend)) begin
                        main_kind = op_kind(r_pend, 1'b1);
                        main_end  = p_end1;
                        n_mode    = MODE_IDLE;
                    end else begin
                        main_kind = op_kind(r_pend, 1'b0);
                        do_start  = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        main_v    = 1'b1;
                        main_kind = K_SLASH;
                        do_start  = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        main_v    = 1'b1;
                        main_kind = K_STRING;
                        main_end  = p_end1;
                        n_mode    = MODE_IDLE;
                    end else if (c == CH_BACKSLASH) begin
                        n_mode = MODE_STRING_ESC;
                    end
                end
                MODE_STRING_ESC: begin
                    n_mode = MODE_STRING;
                end
                MODE_NUMBER: begin
                    if (c == CH_DOT) begin
                        n_mode = MODE_NUMBER_DOT;
                    end else if (!is_digit(c)) begin
                        main_v    = 1'b1;
                        main_kind = K_INTEGER;
                        do_start  = 1'b1;
                    end
                end
                MODE_NUMBER_DOT: begin
                    if (is_digit(c)) begin
                        n_mode = MODE_DECIMAL;
                    end else begin
                        // The dot did not start a fraction: integer, then dot.
                        main_v    = 1'b1;
                        main_kind = K_INTEGER;
                        main_end  = EW'(dot_pos);
                        dot_v     = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                MODE_DECIMAL: begin
                    if (!is_digit(c)) begin
                        main_v    = 1'b1;
                        main_kind = K_DECIMAL;
                        do_start  = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (!(is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE))) begin
                        main_v    = 1'b1;
                        main_kind = K_IDENT;
                        do_start  = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
            if (do_start) begin
                n_mode  = s_mode;
                n_pend  = s_pend;
                n_begin = r_pos;
            end
        end
    end

    // Position after this byte; it stops at its maximum.
    assign n_pos    = (has && (r_pos != '1)) ? r_pos + OB'(1) : r_pos;
    assign fdot_pos = (n_pos != '0) ? n_pos - OB'(1) : '0;

    // End of source: flush whatever is held.
    always_comb begin
        fl_v    = 1'b0;
        fdot_v  = 1'b0;
        fl_kind = K_UNKNOWN;
        fl_end  = EW'(n_pos);
        if (fin) begin
            case (n_mode)
                MODE_OP: begin
                    fl_v    = 1'b1;
                    fl_kind = op_kind(n_pend, 1'b0);
                end
                MODE_SLASH: begin
                    fl_v    = 1'b1;
                    fl_kind = K_SLASH;
                end
                MODE_STRING, MODE_STRING_ESC: begin
                    fl_v    = 1'b1;
                    fl_kind = K_STRING;
                end
                MODE_NUMBER: begin
                    fl_v    = 1'b1;
                    fl_kind = K_INTEGER;
                end
                MODE_NUMBER_DOT: begin
                    fl_v    = 1'b1;
                    fl_kind = K_INTEGER;
                    fl_end  = EW'(fdot_pos);
                    fdot_v  = 1'b1;
                end
                MODE_DECIMAL: begin
                    fl_v    = 1'b1;
                    fl_kind = K_DECIMAL;
                end
                MODE_IDENT: begin
                    fl_v    = 1'b1;
                    fl_kind = K_IDENT;
                end
                default: begin
                    fl_v = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        cand[C_MAIN]  = make_token(main_kind, r_begin, main_end);
        cand[C_DOT]   = make_token(K_DOT, dot_pos, EW'(dot_pos) + EW'(1));
        cand[C_START] = make_token(s_kind, r_pos, p_end1);
        cand[C_FLUSH] = make_token(fl_kind, n_begin, fl_end);
        cand[C_FDOT]  = make_token(K_DOT, fdot_pos, EW'(fdot_pos) + EW'(1));
        cand[C_END]   = make_token(K_END, n_pos, EW'(n_pos));
        cand_v[C_MAIN]  = main_v;
        cand_v[C_DOT]   = dot_v;
        cand_v[C_START] = do_start && s_emit;
        cand_v[C_FLUSH] = fl_v;
        cand_v[C_FDOT]  = fdot_v;
        cand_v[C_END]   = fin;
    end

    // Pack the live candidates in order; anything past the fourth is dropped.
    always_comb begin
        packed_res = '0;
        cnt        = '0;
        for (int i = 0; i < NUM_CAND; i++) begin
            if (cand_v[i] && (cnt < RESULT_CNT_W'(MAX_RESULTS))) begin
                packed_res.tok[cnt[SW-1:0]] = cand[i];
                cnt = cnt + RESULT_CNT_W'(1);
            end
        end
        if (cnt != '0) begin
            packed_res.tok[SW'(cnt - RESULT_CNT_W'(1))].last_of_run = 1'b1;
        end
        packed_res.count = i_accept ? cnt : '0;
    end

    assign o_result = packed_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pend  <= '0;
            r_begin <= '0;
            r_pos   <= '0;
        end else if (i_accept) begin
            if (fin) begin
                r_mode  <= MODE_IDLE;
                r_pend  <= '0;
                r_begin <= '0;
                r_pos   <= '0;
            end else begin
                r_mode  <= n_mode;
                r_pend  <= n_pend;
                r_begin <= n_begin;
                r_pos   <= n_pos;
            end
        end
    end

    // A finished source leaves the scanner as after reset.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && fin) |=> (r_mode == MODE_IDLE) && (r_pos == '0) && (r_begin == '0))
        else $error("scanner state not cleared after end of source");

    // An end-of-source transfer always produces at least one token.
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && fin) |-> (o_result.count != '0))
        else $error("end of source produced no token");

    // An empty transfer produces nothing and leaves the position alone.
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !has && !fin) |-> (o_result.count == '0) ##1 $stable(r_pos))
        else $error("empty transfer had an effect");

endmodule

// File: rtl/core/sbt_token_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_token_queue
// Small token queue: takes up to four tokens per cycle, gives one per cycle
// on a valid/ready channel straight from its storage registers.
// ----------------------------------------------------------------------------
module sbt_token_queue
    import sbt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_scan_result i_push,
    output logic         o_space,
    output logic         o_valid,
    input  logic         i_ready,
    output t_token       o_token
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_token        r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_token = r_slot[r_head];
    assign pop     = o_valid && i_ready;
    // Room for a full burst is required before the next input transfer.
    assign o_space = (r_count <= CW'(QUEUE_DEPTH - MAX_RESULTS));

    assign n_head  = pop ? r_head + PW'(1) : r_head;
    assign n_tail  = r_tail + PW'(i_push.count);
    assign n_count = r_count + CW'(i_push.count) - CW'(pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RESULT_CNT_W'(k) < i_push.count) begin
                r_slot[r_tail + PW'(k)] <= i_push.tok[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("token queue count out of range");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_tail - r_head) == r_count[PW-1:0])
        else $error("token queue pointers disagree with count");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != '0) |-> o_space)
        else $error("tokens pushed without room for a full burst");

endmodule
